/* rtl/lkvc_pkg.sv */
// lkvc_pkg: shared constants and types for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_dpath and lru_key_value_cache; depends on nothing.
`default_nettype none
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int WORD_W  = 32;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

	typedef struct packed {
		logic               stall;
		logic [CNT_W-1:0]   fill;
		logic [ENTRIES-1:0] valid;
	} status_t;

endpackage
`default_nettype wire

/* rtl/lkvc_ctrl.sv */
// lkvc_ctrl: two-state sequencer, takes a beat then runs the update state, which a stall can hold.
// Depends on lkvc_pkg.
`default_nettype none
module lkvc_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  lkvc_pkg::status_t  status,
	output lkvc_pkg::ctrl_t    ctrl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready  = (state_q == ST_IDLE);
	assign ctrl.load = s_tvalid && s_tready;
	assign ctrl.exec = (state_q == ST_EXEC) && !status.stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (ctrl.load) state_d = ST_EXEC;
			ST_EXEC: if (ctrl.exec) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/lkvc_dpath.sv */
// lkvc_dpath: entry store, parallel key match, recency ranks and result register.
// Depends on lkvc_pkg.
`default_nettype none
module lkvc_dpath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  lkvc_pkg::ctrl_t                     ctrl,
	output lkvc_pkg::status_t                   status,
	input  wire [2*lkvc_pkg::WORD_W-1:0]        s_tdata,
	input  wire                                 s_tuser,
	input  wire                                 cfg_wen,
	input  wire [lkvc_pkg::CAP_W-1:0]           cfg_wdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [lkvc_pkg::WORD_W-1:0]         m_tdata,
	output logic                                m_tuser
);

	localparam int N  = lkvc_pkg::ENTRIES;
	localparam int IW = lkvc_pkg::IDX_W;
	localparam int CW = lkvc_pkg::CNT_W;
	localparam int MW = lkvc_pkg::CMP_W;
	localparam int WW = lkvc_pkg::WORD_W;

	// request beat
	logic          op_q;
	logic [WW-1:0] key_q;
	logic [WW-1:0] val_q;

	logic [N-1:0]  valid_q;
	logic [WW-1:0] key_mem_q [N];
	logic [WW-1:0] val_mem_q [N];
	logic [IW-1:0] rank_q    [N];
	logic [CW-1:0] fill_q;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	logic          out_valid_q;
	logic          out_found_q;
	logic [WW-1:0] out_data_q;

	logic [N-1:0]  hit_vec;
	logic          hit;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] hit_rank;
	logic [N-1:0]  victim_vec;
	logic [IW-1:0] victim_idx;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] slot_idx;
	logic [IW-1:0] lru_rank;
	logic [MW-1:0] cap_eff;
	logic [MW-1:0] cap_ext;
	logic          evict;
	logic          is_get;
	logic [IW-1:0] rank_d [N];

	assign cap_ext = MW'(cap_q);
	assign cap_eff = (cap_ext == '0) ? MW'(1) :
	                 (cap_ext > MW'(N)) ? MW'(N) : cap_ext;
	assign evict    = MW'(fill_q) >= cap_eff;
	assign lru_rank = IW'(fill_q - CW'(1));
	assign is_get   = (op_q == lkvc_pkg::OP_GET);

	always_comb begin
		hit_idx    = '0;
		victim_idx = '0;
		for (int i = 0; i < N; i++) begin
			hit_vec[i]    = valid_q[i] && (key_mem_q[i] == key_q);
			victim_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
			if (hit_vec[i])    hit_idx    = hit_idx    | IW'(i);
			if (victim_vec[i]) victim_idx = victim_idx | IW'(i);
		end
		hit = |hit_vec;
	end

	// lowest free entry
	always_comb begin
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IW'(i);
		end
	end

	assign hit_rank = rank_q[hit_idx];
	assign slot_idx = evict ? victim_idx : free_idx;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank_d[i] = rank_q[i];
			if (hit) begin
				if (IW'(i) == hit_idx)
					rank_d[i] = '0;
				else if (valid_q[i] && rank_q[i] < hit_rank)
					rank_d[i] = rank_q[i] + IW'(1);
			end else if (!is_get) begin
				if (IW'(i) == slot_idx)
					rank_d[i] = '0;
				else if (valid_q[i])
					rank_d[i] = rank_q[i] + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fill_q      <= '0;
			cap_q       <= lkvc_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) cap_q <= cfg_wdata;
			out_valid_q <= (out_valid_q && !m_tready) || (ctrl.exec && is_get);
			if (ctrl.exec && !is_get && !hit) begin
				valid_q[slot_idx] <= 1'b1;
				if (!evict) fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= s_tdata[WW-1:0];
			val_q <= s_tdata[2*WW-1:WW];
			op_q  <= s_tuser;
		end
		if (ctrl.exec) begin
			for (int i = 0; i < N; i++) rank_q[i] <= rank_d[i];
			if (is_get) begin
				out_found_q <= hit;
				out_data_q  <= hit ? val_mem_q[hit_idx] : '0;
			end else if (hit) begin
				val_mem_q[hit_idx] <= val_q;
			end else begin
				key_mem_q[slot_idx] <= key_q;
				val_mem_q[slot_idx] <= val_q;
			end
		end
	end

	assign status.stall = is_get && out_valid_q && !m_tready;
	assign status.fill  = fill_q;
	assign status.valid = valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

endmodule
`default_nettype wire

/* rtl/lru_key_value_cache.sv */
// Fully associative 16-entry key-value cache, LRU replacement.
// The beat is captured, then the update state registers the get result;
// the sequencer takes no new request until the update state ends;
// a get waits in the update cycle while the previous result is not taken.
// Reset (arst_n low): cache empty, capacity 16, no result pending.
`default_nettype none
module lru_key_value_cache (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [2*lkvc_pkg::WORD_W-1:0]        s_tdata,  // key, value
	input  wire                                 s_tuser,  // operation
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [lkvc_pkg::WORD_W-1:0]         m_tdata,  // data
	output logic                                m_tuser,  // found
	input  wire                                 cfg_wen,
	input  wire [lkvc_pkg::CAP_W-1:0]           cfg_wdata
);

	lkvc_pkg::ctrl_t   ctrl;
	lkvc_pkg::status_t status;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.ctrl     (ctrl)
	);

	lkvc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.fill <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
		else $error("fill count beyond entries");

	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(status.valid) == int'(status.fill))
		else $error("fill count disagrees with valid entries");

	a_set_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == lkvc_pkg::OP_SET && !m_tvalid)
		|=> ##1 !m_tvalid)
		else $error("set beat produced a result");
`endif

endmodule
`default_nettype wire
